// File: hdl/rau_pkg.sv
// Package for the rational arithmetic unit: payload types, codes and control structs.
package rau_pkg;

    localparam logic [1:0] FUNC_ADD = 2'd0;
    localparam logic [1:0] FUNC_SUB = 2'd1;
    localparam logic [1:0] FUNC_MUL = 2'd2;
    localparam logic [1:0] FUNC_DIV = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    localparam logic [1:0] MSEL_P1  = 2'd0;
    localparam logic [1:0] MSEL_P2  = 2'd1;
    localparam logic [1:0] MSEL_DEN = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic [1:0]         status;
    } t_out_res;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       comb;
        logic       gcd_step;
        logic       div_init;
        logic       div_step;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic gcd_done;
        logic div_last;
    } t_sts;

endpackage

// File: hdl/rational_arith_unit.sv
// Top level of the rational arithmetic unit: controller plus datapath.
//
// The block takes one request on the input channel (i_in_valid / o_in_stall),
// made of an operation code and two signed rationals, and returns one result
// on the output channel (o_out_valid / i_out_stall). The result is in lowest
// terms with a positive denominator, together with a status code that flags
// a zero denominator or divisor, or a reduced value that does not fit.
// A request is taken at a clock edge where valid is high and stall is low.
// Each request goes through three multiplies, one combine step, a binary gcd
// (one subtract or shift per cycle over the double width values) and a divider
// that produces both reduced parts at once, and then the output register load.
// One request is worked on at a time; o_in_stall is high while it runs.
// A finished result sits in the output register while i_out_stall is high,
// and the next request can already be taken and worked on meanwhile.
// A synchronous active-low reset returns the controller to idle and clears
// the output valid flag.
module rational_arith_unit import rau_pkg::*; #(
    parameter int WIDTH = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_res o_out_res
);

    t_cmd w_cmd;
    t_sts w_sts;

    // The controller sequences the multiply, gcd and divide phases.
    rau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // The datapath holds operands, the shared multiplier, gcd and divider.
    rau_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk (i_clk),
        .i_req (i_in_req),
        .i_cmd (w_cmd),
        .o_sts (w_sts),
        .o_res (o_out_res)
    );

endmodule

// File: hdl/rau_ctrl.sv
// Controller state machine of the rational arithmetic unit.
module rau_ctrl import rau_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_A, S_MUL_B, S_MUL_C, S_COMB, S_GCD, S_DIV, S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL_A;
                end
            end
            S_MUL_A: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MSEL_P1;
                n_state       = S_MUL_B;
            end
            S_MUL_B: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MSEL_P2;
                n_state       = S_MUL_C;
            end
            S_MUL_C: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MSEL_DEN;
                n_state       = S_COMB;
            end
            S_COMB: begin
                o_cmd.comb = 1'b1;
                n_state    = S_GCD;
            end
            S_GCD: begin
                if (i_sts.gcd_done) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = o_cmd.out_load | (r_out_valid & i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: hdl/rau_dp.sv
// Datapath of the rational arithmetic unit: multiplier, binary gcd and divider.
module rau_dp import rau_pkg::*; #(
    parameter int WIDTH = 32
) (
    input  logic     i_clk,
    input  t_in_req  i_req,
    input  t_cmd     i_cmd,
    output t_sts     o_sts,
    output t_out_res o_res
);

    localparam int EW = (WIDTH < 32) ? WIDTH : 32;
    localparam int PW = 2 * EW;
    localparam int KW = $clog2(PW) + 1;
    localparam int CW = $clog2(PW);

    logic [1:0]    r_func;
    logic [EW-1:0] r_an, r_ad, r_bn, r_bd;
    logic          r_an_s, r_ad_s, r_bn_s, r_bd_s, r_zero;
    logic [PW-1:0] r_p1, r_p2, r_pd;
    logic          r_s;
    logic [PW-1:0] r_u, r_v;
    logic [KW-1:0] r_k;
    logic [PW-1:0] r_g, r_mag, r_den;
    logic [PW-1:0] r_qn, r_qd;
    logic [PW:0]   r_rn, r_rd;
    logic [CW-1:0] r_cnt;
    t_out_res      r_res;
    t_out_res      w_fin;

    function automatic logic [EW:0] split(input logic [31:0] raw);
        logic [EW-1:0] v;
        v = raw[EW-1:0];
        return {v[EW-1], v[EW-1] ? (~v + 1'b1) : v};
    endfunction

    logic [EW:0] w_an, w_ad, w_bn, w_bd;
    assign w_an = split(i_req.a_num);
    assign w_ad = split(i_req.a_den);
    assign w_bn = split(i_req.b_num);
    assign w_bd = split(i_req.b_den);

    // Shared multiplier with selected operands.
    logic [EW-1:0] w_ma, w_mb;
    logic [PW-1:0] w_prod;
    always_comb begin
        w_ma = r_an;
        w_mb = r_bd;
        unique case (i_cmd.mul_sel)
            MSEL_P1:  begin
                w_ma = r_an;
                w_mb = (r_func == FUNC_MUL) ? r_bn : r_bd;
            end
            MSEL_P2:  begin
                w_ma = r_bn;
                w_mb = r_ad;
            end
            MSEL_DEN: begin
                w_ma = r_ad;
                w_mb = (r_func == FUNC_DIV) ? r_bn : r_bd;
            end
            default:  begin
                w_ma = r_an;
                w_mb = r_bd;
            end
        endcase
        w_prod = PW'(w_ma) * PW'(w_mb);
    end

    // Sign and magnitude of the unreduced result.
    logic          w_s1, w_s2, w_sd, w_s;
    logic [PW-1:0] w_mag;
    always_comb begin
        w_s1 = r_an_s ^ ((r_func == FUNC_MUL) ? r_bn_s : r_bd_s);
        w_s2 = (r_bn_s ^ r_ad_s) ^ (r_func == FUNC_SUB);
        w_sd = r_ad_s ^ ((r_func == FUNC_DIV) ? r_bn_s : r_bd_s);
        if (r_func == FUNC_MUL || r_func == FUNC_DIV) begin
            w_mag = r_p1;
            w_s   = w_s1;
        end else if (w_s1 == w_s2) begin
            w_mag = r_p1 + r_p2;
            w_s   = w_s1;
        end else if (r_p1 >= r_p2) begin
            w_mag = r_p1 - r_p2;
            w_s   = w_s1;
        end else begin
            w_mag = r_p2 - r_p1;
            w_s   = w_s2;
        end
        w_s = (w_s ^ w_sd) & (w_mag != '0);
    end

    // One step of the divider for both dividends.
    logic [PW:0] w_tn, w_td;
    assign w_tn = {r_rn[PW-1:0], r_qn[PW-1]};
    assign w_td = {r_rd[PW-1:0], r_qd[PW-1]};
    logic w_gen, w_ged;
    assign w_gen = w_tn >= {1'b0, r_g};
    assign w_ged = w_td >= {1'b0, r_g};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_req.func;
            {r_an_s, r_an} <= w_an;
            {r_ad_s, r_ad} <= w_ad;
            {r_bn_s, r_bn} <= w_bn;
            {r_bd_s, r_bd} <= w_bd;
            r_zero <= (w_ad[EW-1:0] == '0) || (w_bd[EW-1:0] == '0)
                      || (i_req.func == FUNC_DIV && w_bn[EW-1:0] == '0);
        end
        if (i_cmd.mul_en) begin
            unique case (i_cmd.mul_sel)
                MSEL_P1:  r_p1 <= w_prod;
                MSEL_P2:  r_p2 <= w_prod;
                default:  r_pd <= w_prod;
            endcase
        end
        if (i_cmd.comb) begin
            r_s   <= w_s;
            r_mag <= w_mag;
            r_den <= r_pd;
            r_u   <= w_mag;
            r_v   <= r_pd;
            r_k   <= '0;
        end
        if (i_cmd.gcd_step) begin
            if (!r_u[0] && !r_v[0]) begin
                r_u <= r_u >> 1;
                r_v <= r_v >> 1;
                r_k <= r_k + 1'b1;
            end else if (!r_u[0]) begin
                r_u <= r_u >> 1;
            end else if (!r_v[0]) begin
                r_v <= r_v >> 1;
            end else if (r_u >= r_v) begin
                r_u <= (r_u - r_v) >> 1;
            end else begin
                r_v <= (r_v - r_u) >> 1;
            end
        end
        if (i_cmd.div_init) begin
            r_g   <= r_v << r_k;
            r_qn  <= r_mag;
            r_qd  <= r_den;
            r_rn  <= '0;
            r_rd  <= '0;
            r_cnt <= CW'(PW - 1);
        end
        if (i_cmd.div_step) begin
            r_rn  <= w_gen ? (w_tn - {1'b0, r_g}) : w_tn;
            r_rd  <= w_ged ? (w_td - {1'b0, r_g}) : w_td;
            r_qn  <= {r_qn[PW-2:0], w_gen};
            r_qd  <= {r_qd[PW-2:0], w_ged};
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.out_load) r_res <= w_fin;
    end

    // Range check and final packing.
    logic [63:0] w_lim, w_n64, w_d64, w_neg;
    always_comb begin
        w_lim = 64'd1 << (EW - 1);
        w_n64 = 64'(r_qn);
        w_d64 = 64'(r_qd);
        w_neg = r_s ? (64'd0 - w_n64) : w_n64;
        if (r_zero) begin
            w_fin.res_num = '0;
            w_fin.res_den = 31'd1;
            w_fin.status  = ST_ZERO;
        end else if (w_d64 > w_lim - 64'd1
                     || w_n64 > (r_s ? w_lim : w_lim - 64'd1)) begin
            w_fin.res_num = '0;
            w_fin.res_den = 31'd1;
            w_fin.status  = ST_OVF;
        end else begin
            w_fin.res_num = w_neg[31:0];
            w_fin.res_den = w_d64[30:0];
            w_fin.status  = ST_OK;
        end
    end

    // A zero denominator leaves nothing to reduce, so the gcd loop is skipped.
    assign o_sts.gcd_done = (r_u == '0) || r_zero;
    assign o_sts.div_last = (r_cnt == '0);
    assign o_res          = r_res;

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for the rational arithmetic unit.
`timescale 1ns / 100ps

module tb_top;
    import rau_pkg::*;

    localparam int WIDTH      = 32;
    localparam int IDLE_LIMIT = 20000;
    localparam int N_RANDOM   = 2000;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_stall;
    t_in_req  i_in_req;
    logic     o_out_valid;
    logic     i_out_stall;
    t_out_res o_out_res;

    rational_arith_unit #(.WIDTH(WIDTH)) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_req   (i_in_req),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_res  (o_out_res)
    );

    // One directed row: a request and, where it is obvious, the result it must give.
    typedef struct {
        t_in_req  req;
        int       typed;
        t_out_res res;
    } t_row;

    t_out_res expected_results[$];
    int       error_count;
    int       idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Splits an operand into sign and magnitude; the most negative value keeps its
    // full magnitude of 2**31 because the magnitude is held at 64 bits.
    function automatic void sign_mag(input logic [31:0] raw, output bit neg,
                                     output logic [63:0] mag);
        neg = raw[31];
        mag = neg ? (64'd0 - {32'd0, raw}) & 64'hFFFF_FFFF : {32'd0, raw};
    endfunction

    function automatic logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Computes the reduced rational result of one request.
    function automatic t_out_res reduce_rational(input t_in_req rq);
        t_out_res    r;
        bit          an_s, ad_s, bn_s, bd_s, s, s1, s2, sd;
        logic [63:0] an, ad, bn, bd, mag, den, p1, p2, g, lim;
        sign_mag(rq.a_num, an_s, an);
        sign_mag(rq.a_den, ad_s, ad);
        sign_mag(rq.b_num, bn_s, bn);
        sign_mag(rq.b_den, bd_s, bd);
        r.res_num = '0;
        r.res_den = 31'd1;
        if (ad == 0 || bd == 0 || (rq.func == FUNC_DIV && bn == 0)) begin
            r.status = ST_ZERO;
            return r;
        end
        case (rq.func)
            FUNC_ADD, FUNC_SUB: begin
                p1 = an * bd;
                p2 = bn * ad;
                s1 = an_s != bd_s;
                s2 = (bn_s != ad_s) != (rq.func == FUNC_SUB);
                if (s1 == s2) begin
                    mag = p1 + p2;
                    s = s1;
                end else if (p1 >= p2) begin
                    mag = p1 - p2;
                    s = s1;
                end else begin
                    mag = p2 - p1;
                    s = s2;
                end
                den = ad * bd;
                sd = ad_s != bd_s;
            end
            FUNC_MUL: begin
                mag = an * bn;
                s = an_s != bn_s;
                den = ad * bd;
                sd = ad_s != bd_s;
            end
            default: begin
                mag = an * bd;
                s = an_s != bd_s;
                den = ad * bn;
                sd = ad_s != bn_s;
            end
        endcase
        s = s != sd;
        if (mag == 0) s = 1'b0;
        g = gcd64(mag, den);
        mag = mag / g;
        den = den / g;
        lim = 64'd1 << 31;
        if (den > lim - 1 || mag > (s ? lim : lim - 1)) begin
            r.status = ST_OVF;
            return r;
        end
        mag = s ? (64'd0 - mag) : mag;
        r.res_num = mag[31:0];
        r.res_den = den[30:0];
        r.status  = ST_OK;
        return r;
    endfunction

    // Short gaps most of the time, a long one now and then, none for long stretches.
    function automatic int gap_len(input bit quiet);
        int p;
        if (quiet) return 0;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // Operands biased toward small values, extremes and signs, so that the gcd
    // reduction and the overflow check both see real work.
    function automatic logic [31:0] rand_operand();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return $urandom_range(0, 40) - 20;
        if (p < 60) return $urandom_range(0, 2000) - 1000;
        if (p < 70) begin
            case ($urandom_range(0, 4))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h8000_0001;
                3: return 32'hFFFF_FFFF;
                default: return 32'h0000_0001;
            endcase
        end
        if (p < 85) return $urandom_range(0, 65535) * ($urandom_range(0, 1) ? 1 : -1);
        return $urandom;
    endfunction

    // Drives one request at the falling edge and holds it until it is taken.
    // The task returns at a falling edge with the taken request still on the
    // bus; the next request, or an explicit idle, replaces it there.
    task automatic send_request(input t_in_req rq, input bit quiet);
        int n;
        n = gap_len(quiet);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            i_in_req   <= '0;
            repeat (n) @(negedge i_clk);
        end
        i_in_req   <= rq;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        expected_results.push_back(reduce_rational(rq));
        @(negedge i_clk);
    endtask

    function automatic t_in_req mk(input logic [1:0] f, input logic [31:0] an,
                                   input logic [31:0] ad, input logic [31:0] bn,
                                   input logic [31:0] bd);
        t_in_req rq;
        rq.func  = f;
        rq.a_num = an;
        rq.a_den = ad;
        rq.b_num = bn;
        rq.b_den = bd;
        return rq;
    endfunction

    function automatic t_out_res mr(input logic [31:0] n, input logic [31:0] d,
                                    input logic [1:0] st);
        t_out_res r;
        r.res_num = n;
        r.res_den = d[30:0];
        r.status  = st;
        return r;
    endfunction

    // Receiver: random stall, checks each taken result against the oldest expectation.
    initial begin
        i_out_stall = 1'b1;
        @(negedge i_clk);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 99) < 30) begin
                i_out_stall <= 1'b1;
                if ($urandom_range(0, 99) < 5) begin
                    repeat ($urandom_range(10, 200)) @(negedge i_clk);
                end
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result num=%0d den=%0d status=%0d", $time,
                         o_out_res.res_num, o_out_res.res_den, o_out_res.status);
                error_count++;
            end else begin
                if (o_out_res.res_num !== expected_results[0].res_num) begin
                    $display("%0t: res_num expected %0d actual %0d", $time,
                             expected_results[0].res_num, o_out_res.res_num);
                    error_count++;
                end
                if (o_out_res.res_den !== expected_results[0].res_den) begin
                    $display("%0t: res_den expected %0d actual %0d", $time,
                             expected_results[0].res_den, o_out_res.res_den);
                    error_count++;
                end
                if (o_out_res.status !== expected_results[0].status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             expected_results[0].status, o_out_res.status);
                    error_count++;
                end
                void'(expected_results.pop_front());
            end
        end
    end

    // Watchdog: counts cycles in which neither channel takes anything.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        t_row    rows[$];
        t_in_req rq;
        t_out_res got;
        error_count = 0;
        idle_cycles = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_req    = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: zero denominators, zero divisor, extremes, every operation.
        rows.push_back('{mk(FUNC_ADD, 1, 0, 1, 1), 1, mr(0, 1, ST_ZERO)});
        rows.push_back('{mk(FUNC_SUB, 1, 1, 1, 0), 1, mr(0, 1, ST_ZERO)});
        rows.push_back('{mk(FUNC_DIV, 3, 4, 0, 7), 1, mr(0, 1, ST_ZERO)});
        rows.push_back('{mk(FUNC_MUL, 0, 5, 9, -3), 1, mr(0, 1, ST_OK)});
        rows.push_back('{mk(FUNC_ADD, 1, 2, 1, 2), 1, mr(1, 1, ST_OK)});
        rows.push_back('{mk(FUNC_SUB, 1, 3, 1, 3), 1, mr(0, 1, ST_OK)});
        rows.push_back('{mk(FUNC_MUL, 2, -4, 3, 6), 1, mr(-1, 4, ST_OK)});
        rows.push_back('{mk(FUNC_DIV, 1, 2, 1, 4), 1, mr(2, 1, ST_OK)});
        rows.push_back('{mk(FUNC_MUL, 32'h8000_0000, 1, 1, 1), 1,
                         mr(32'h8000_0000, 1, ST_OK)});
        rows.push_back('{mk(FUNC_MUL, 32'h8000_0000, 1, -1, 1), 1, mr(0, 1, ST_OVF)});
        rows.push_back('{mk(FUNC_ADD, 32'h7FFF_FFFF, 1, 1, 1), 1, mr(0, 1, ST_OVF)});
        rows.push_back('{mk(FUNC_MUL, 1, 32'h8000_0000, 1, 1), 1, mr(0, 1, ST_OVF)});
        rows.push_back('{mk(FUNC_MUL, -1, 32'h8000_0000, 1, 1), 1, mr(0, 1, ST_OVF)});
        rows.push_back('{mk(FUNC_DIV, 1, 1, 32'h8000_0000, 2), 1,
                         mr(-1, 32'h4000_0000, ST_OK)});
        rows.push_back('{mk(FUNC_MUL, 2, 32'h8000_0000, 1, 1), 1,
                         mr(-1, 32'h4000_0000, ST_OK)});
        rows.push_back('{mk(FUNC_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h8000_0000, 32'h8000_0000), 1, mr(2, 1, ST_OK)});
        rows.push_back('{mk(FUNC_SUB, 32'h7FFF_FFFF, 32'h8000_0001, 1, -1), 1,
                         mr(0, 1, ST_OK)});
        rows.push_back('{mk(FUNC_ADD, 3, 7, -5, 11), 0, '0});
        rows.push_back('{mk(FUNC_SUB, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                            32'h7FFF_FFFE), 0, '0});
        rows.push_back('{mk(FUNC_DIV, 32'h1234_5678, -97, 32'hFEDC_BA98, 65536), 0, '0});
        rows.push_back('{mk(FUNC_MUL, 65536, 65535, -65535, 65536), 0, '0});

        foreach (rows[i]) begin
            if (rows[i].typed != 0) begin
                got = reduce_rational(rows[i].req);
                if (got !== rows[i].res) begin
                    $display("%0t: directed row %0d expected %h actual %h", $time, i,
                             rows[i].res, got);
                    error_count++;
                end
            end
            send_request(rows[i].req, i < 8);
        end

        for (int k = 0; k < N_RANDOM; k++) begin
            // Pause once until every result has come back.
            if (k == N_RANDOM / 2) begin
                i_in_valid <= 1'b0;
                i_in_req   <= '0;
                while (expected_results.size() != 0) @(negedge i_clk);
            end
            rq.func  = 2'($urandom_range(0, 3));
            rq.a_num = rand_operand();
            rq.a_den = rand_operand();
            rq.b_num = rand_operand();
            rq.b_den = rand_operand();
            send_request(rq, (k % 400) < 60);
        end

        i_in_valid <= 1'b0;
        i_in_req   <= '0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
